/* hdl/tftp_read_transfer_control_macros.svh */
// Assertion macros shared by the TFTP read transfer control RTL.
// Needs nothing else. It is included by the modules that carry assertions.
`ifndef TFTP_READ_TRANSFER_CONTROL_MACROS_SVH
`define TFTP_READ_TRANSFER_CONTROL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tftp_rtc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tftp_rtc: next-cycle check failed");

`endif

/* hdl/tftp_rtc_pkg.sv */
// Types, codes and helper functions of the TFTP read transfer control.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package tftp_rtc_pkg;

    localparam logic [15:0] DEFAULT_BLKSIZE = 16'd512;
    localparam int          FIFO_DEPTH      = 8;
    localparam int          FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int          FIFO_LVL_W      = $clog2(FIFO_DEPTH + 1);
    localparam int          MAX_RESULTS     = 3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FIRST = 3'd1,
        PH_XFER  = 3'd2,
        PH_DONE  = 3'd3,
        PH_FAIL  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_DATA      = 3'd1,
        OP_OACK      = 3'd2,
        OP_ERROR     = 3'd3,
        OP_TIMEOUT   = 3'd4,
        OP_OTHER     = 3'd5,
        OP_INTERRUPT = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        ACT_SEND_RRQ   = 3'd0,
        ACT_SEND_ACK   = 3'd1,
        ACT_WRITE_DATA = 3'd2,
        ACT_SEND_ERROR = 3'd3,
        ACT_DONE       = 3'd4,
        ACT_FAILED     = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TIMEOUT     = 3'd1,
        ST_ILLEGAL_OP  = 3'd2,
        ST_SERVER_ERR  = 3'd3,
        ST_INTERRUPTED = 3'd4
    } t_status;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] packet_block;
        logic [15:0] payload_length;
        logic [15:0] offered_block_size;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [15:0] ack_block;
        logic [15:0] write_length;
        t_status     status;
        logic        last_of_run;
    } t_result;

    // All results caused by one item, in delivery order from index 0.
    typedef struct packed {
        logic [1:0]                    count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_run;

    function automatic t_result f_res(t_action act, logic [15:0] ack, logic [15:0] len,
                                      t_status st);
        t_result r;
        r.action       = act;
        r.ack_block    = ack;
        r.write_length = len;
        r.status       = st;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tftp_rtc_decide.sv */
// Transfer state and event decoding of the TFTP read transfer control.
// Depends on tftp_rtc_pkg. Turns one registered event into up to three results.
`default_nettype none

module tftp_rtc_decide
    import tftp_rtc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_item      i_item,
    input  wire logic [7:0] i_retry_limit,
    output t_run            o_run
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_cur, n_cur;
    logic [7:0]  r_rc, n_rc;
    logic [15:0] r_bs, n_bs;

    logic [16:0] want;
    logic [7:0]  rc_inc;
    logic        retry_fail;
    logic        first;
    t_run        run;

    assign want       = {1'b0, r_cur} + 17'd1;
    assign rc_inc     = (r_rc != 8'hFF) ? r_rc + 8'd1 : r_rc;
    assign retry_fail = (rc_inc >= i_retry_limit);
    assign first      = (r_phase == PH_FIRST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cur   <= 16'd0;
            r_rc    <= 8'd0;
            r_bs    <= DEFAULT_BLKSIZE;
        end else begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_rc    <= n_rc;
            r_bs    <= n_bs;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cur   = r_cur;
        n_rc    = r_rc;
        n_bs    = r_bs;
        run     = '0;
        if (i_valid) begin
            if (i_item.opcode == OP_START) begin
                n_phase    = PH_FIRST;
                n_cur      = 16'd0;
                n_rc       = 8'd0;
                n_bs       = DEFAULT_BLKSIZE;
                run.count  = 2'd1;
                run.res[0] = f_res(ACT_SEND_RRQ, 16'd0, 16'd0, ST_OK);
            end else if (r_phase == PH_FIRST || r_phase == PH_XFER) begin
                unique case (i_item.opcode)
                    OP_DATA: begin
                        if ((first && i_item.packet_block == 16'd1) ||
                            (!first && {1'b0, i_item.packet_block} == want)) begin
                            // Next block in order: store it, acknowledge it, and finish
                            // on a short block.
                            n_cur      = i_item.packet_block;
                            n_rc       = 8'd0;
                            if (first) begin
                                n_bs = DEFAULT_BLKSIZE;
                            end
                            run.res[0] = f_res(ACT_WRITE_DATA, 16'd0, i_item.payload_length,
                                               ST_OK);
                            run.res[1] = f_res(ACT_SEND_ACK, i_item.packet_block, 16'd0, ST_OK);
                            if (i_item.payload_length < (first ? DEFAULT_BLKSIZE : r_bs)) begin
                                n_phase    = PH_DONE;
                                run.count  = 2'd3;
                                run.res[2] = f_res(ACT_DONE, 16'd0, 16'd0, ST_OK);
                            end else begin
                                n_phase   = PH_XFER;
                                run.count = 2'd2;
                            end
                        end else if (!first && {1'b0, i_item.packet_block} < want) begin
                            // A stale block counts as a retry.
                            n_rc      = rc_inc;
                            run.count = 2'd1;
                            if (retry_fail) begin
                                n_phase    = PH_FAIL;
                                run.res[0] = f_res(ACT_FAILED, 16'd0, 16'd0, ST_TIMEOUT);
                            end else begin
                                run.res[0] = f_res(ACT_SEND_ACK, r_cur, 16'd0, ST_OK);
                            end
                        end else begin
                            n_phase    = PH_FAIL;
                            run.count  = 2'd1;
                            run.res[0] = f_res(ACT_FAILED, 16'd0, 16'd0, ST_ILLEGAL_OP);
                        end
                    end
                    OP_OACK: begin
                        run.count = 2'd1;
                        if (first) begin
                            n_bs       = (i_item.offered_block_size != 16'd0) ?
                                         i_item.offered_block_size : DEFAULT_BLKSIZE;
                            n_cur      = 16'd0;
                            n_rc       = 8'd0;
                            n_phase    = PH_XFER;
                            run.res[0] = f_res(ACT_SEND_ACK, 16'd0, 16'd0, ST_OK);
                        end else begin
                            run.res[0] = f_res(ACT_SEND_ACK, r_cur, 16'd0, ST_OK);
                        end
                    end
                    OP_ERROR: begin
                        n_phase    = PH_FAIL;
                        run.count  = 2'd1;
                        run.res[0] = f_res(ACT_FAILED, 16'd0, 16'd0, ST_SERVER_ERR);
                    end
                    OP_TIMEOUT: begin
                        n_rc      = rc_inc;
                        run.count = 2'd1;
                        if (retry_fail) begin
                            n_phase    = PH_FAIL;
                            run.res[0] = f_res(ACT_FAILED, 16'd0, 16'd0, ST_TIMEOUT);
                        end else if (first) begin
                            run.res[0] = f_res(ACT_SEND_RRQ, 16'd0, 16'd0, ST_OK);
                        end else begin
                            run.res[0] = f_res(ACT_SEND_ACK, r_cur, 16'd0, ST_OK);
                        end
                    end
                    OP_OTHER: begin
                        run.count = 2'd1;
                        if (first) begin
                            n_phase    = PH_FAIL;
                            run.res[0] = f_res(ACT_FAILED, 16'd0, 16'd0, ST_ILLEGAL_OP);
                        end else begin
                            run.res[0] = f_res(ACT_SEND_ACK, r_cur, 16'd0, ST_OK);
                        end
                    end
                    OP_INTERRUPT: begin
                        n_phase    = PH_FAIL;
                        run.count  = 2'd2;
                        run.res[0] = f_res(ACT_SEND_ERROR, 16'd0, 16'd0, ST_OK);
                        run.res[1] = f_res(ACT_FAILED, 16'd0, 16'd0, ST_INTERRUPTED);
                    end
                    default: begin
                    end
                endcase
            end
        end
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (2'(j + 1) == run.count) begin
                run.res[j].last_of_run = 1'b1;
            end
        end
    end

    assign o_run = run;

endmodule

`default_nettype wire

/* hdl/tftp_rtc_result_fifo.sv */
// Result queue of the TFTP read transfer control: takes up to three results
// a cycle and hands them out one per transaction. Depends on tftp_rtc_pkg and the macros header.
`default_nettype none
`include "tftp_read_transfer_control_macros.svh"

module tftp_rtc_result_fifo
    import tftp_rtc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_run                  i_run,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output t_result                    o_head,
    output logic [FIFO_LVL_W-1:0]      o_level
);

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wp, r_rp;
    logic [FIFO_LVL_W-1:0]   r_level;
    logic                    pop;

    assign o_valid = (r_level != '0);
    assign pop     = i_pop && o_valid;
    assign o_head  = r_mem[r_rp];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (2'(j) < i_run.count) begin
                r_mem[r_wp + FIFO_PTR_W'(j)] <= i_run.res[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= r_wp + FIFO_PTR_W'(i_run.count);
            r_rp    <= r_rp + FIFO_PTR_W'(pop);
            r_level <= r_level + FIFO_LVL_W'(i_run.count) - FIFO_LVL_W'(pop);
        end
    end

    `RTC_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_level} + (FIFO_LVL_W+1)'(i_run.count) - (FIFO_LVL_W+1)'(pop)) <=
        (FIFO_LVL_W+1)'(FIFO_DEPTH))
    `RTC_ASSERT_NEXT(a_level_tracks, i_clk, i_rst_n, 1'b1,
        r_level == $past(r_level) + FIFO_LVL_W'($past(i_run.count)) - FIFO_LVL_W'($past(pop)))
    `RTC_ASSERT_SAME(a_ptr_gap, i_clk, i_rst_n, r_level < FIFO_LVL_W'(FIFO_DEPTH),
        (r_wp - r_rp) == FIFO_PTR_W'(r_level))

endmodule

`default_nettype wire

/* hdl/tftp_read_transfer_control.sv */
// Client side of a TFTP read transfer: an event enters an input register when
// accepted, is decoded against the transfer state in the next cycle, and its
// results (up to three, the final one marked by tlast) go to an eight-entry
// result queue that drives the master side, one result per transaction. An
// event can be accepted every cycle while the queue has room for the results
// of the event in the input register and of the new one; the first result of
// an event passes the input register and the result queue on its way out, and
// the sustained rate is set by the master side. The retry limit is written
// through the configuration channel, which is always ready. Depends on
// tftp_rtc_pkg, tftp_rtc_decide and tftp_rtc_result_fifo.
`default_nettype none

module tftp_read_transfer_control
    import tftp_rtc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,    // retry limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // packet_block [15:0], payload_length [31:16], offered_block_size [47:32]
    input  wire logic [47:0] s_tdata,
    input  wire logic [2:0]  s_tuser,       // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // ack_block [15:0], write_length [31:16], status [34:32], zero [39:35]
    output logic [39:0]      m_tdata,
    output logic [2:0]       m_tuser,       // action
    output logic             m_tlast        // last_of_run
);

    logic [7:0]            r_retry_limit;
    logic                  r_in_valid;
    t_item                 r_item;
    t_run                  run;
    t_result               head;
    logic [FIFO_LVL_W-1:0] level;
    logic [FIFO_LVL_W:0]   committed;
    logic                  in_accept;

    assign o_cfg_ready = 1'b1;

    // Room is reserved for the event waiting in the input register as well.
    assign committed = {1'b0, level} +
                       ((FIFO_LVL_W+1)'(r_in_valid) * (FIFO_LVL_W+1)'(MAX_RESULTS));
    assign s_tready  = (committed <= (FIFO_LVL_W+1)'(FIFO_DEPTH - MAX_RESULTS));
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= 8'd3;
            r_in_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_retry_limit <= i_cfg_data;
            end
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.opcode             <= t_opcode'(s_tuser);
            r_item.packet_block       <= s_tdata[15:0];
            r_item.payload_length     <= s_tdata[31:16];
            r_item.offered_block_size <= s_tdata[47:32];
        end
    end

    tftp_rtc_decide u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_item        (r_item),
        .i_retry_limit (r_retry_limit),
        .o_run         (run)
    );

    tftp_rtc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .i_pop   (m_tready),
        .o_valid (m_tvalid),
        .o_head  (head),
        .o_level (level)
    );

    assign m_tdata = {5'd0, head.status, head.write_length, head.ack_block};
    assign m_tuser = head.action;
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire
